// ===== sv/shp_pkg.sv =====
// shared types, constants and round functions for the siphash stream hasher
package shp_pkg;

   typedef logic [63:0] word_type;
   typedef logic [7:0]  len_type;
   typedef logic [3:0]  count_type;
   typedef logic [1:0]  csr_index_type;

   typedef struct packed {
      word_type v0;
      word_type v1;
      word_type v2;
      word_type v3;
   } sip_state_type;

   // control from the front end to the absorb stage
   typedef struct packed {
      logic accept;
      logic close;
      logic restart;
   } absorb_ctrl_type;

   // what the absorb stage hands to the finalisation pipeline
   typedef struct packed {
      sip_state_type v;
      word_type      block;
   } fin_handoff_type;

   localparam csr_index_type CSR_KEY_LOW  = 2'd0;
   localparam csr_index_type CSR_KEY_HIGH = 2'd1;

   localparam word_type IV0 = 64'h736f6d6570736575;
   localparam word_type IV1 = 64'h646f72616e646f6d;
   localparam word_type IV2 = 64'h6c7967656e657261;
   localparam word_type IV3 = 64'h7465646279746573;

   localparam count_type MAX_BYTES = 4'd8;
   localparam word_type  FINAL_XOR = 64'h00000000000000ff;
   localparam int unsigned LEN_POS = 56;

   localparam int unsigned ROT_A = 13;
   localparam int unsigned ROT_B = 32;
   localparam int unsigned ROT_C = 16;
   localparam int unsigned ROT_D = 21;
   localparam int unsigned ROT_E = 17;

   function automatic word_type rotl(input word_type x, input int unsigned b);
      return (x << b) | (x >> (64 - b));
   endfunction

   function automatic sip_state_type sip_round(input sip_state_type s);
      sip_state_type r;
      r    = s;
      r.v0 = r.v0 + r.v1;
      r.v1 = rotl(r.v1, ROT_A) ^ r.v0;
      r.v0 = rotl(r.v0, ROT_B);
      r.v2 = r.v2 + r.v3;
      r.v3 = rotl(r.v3, ROT_C) ^ r.v2;
      r.v0 = r.v0 + r.v3;
      r.v3 = rotl(r.v3, ROT_D) ^ r.v0;
      r.v2 = r.v2 + r.v1;
      r.v1 = rotl(r.v1, ROT_E) ^ r.v2;
      r.v2 = rotl(r.v2, ROT_B);
      return r;
   endfunction

   // one message word through two rounds
   function automatic sip_state_type sip_compress(input sip_state_type s, input word_type m);
      sip_state_type r;
      r    = s;
      r.v3 = r.v3 ^ m;
      r    = sip_round(sip_round(r));
      r.v0 = r.v0 ^ m;
      return r;
   endfunction

   function automatic sip_state_type sip_init(input word_type k0, input word_type k1);
      sip_state_type r;
      r.v0 = IV0 ^ k0;
      r.v1 = IV1 ^ k1;
      r.v2 = IV2 ^ k0;
      r.v3 = IV3 ^ k1;
      return r;
   endfunction

endpackage

// ===== sv/shp_absorb.sv =====
// byte packing and word compression stage holding the running hash state
module shp_absorb (
   input  logic                     clock,
   input  logic                     reset,
   input  shp_pkg::absorb_ctrl_type ctrl,
   input  shp_pkg::word_type        key_low,
   input  shp_pkg::word_type        key_high,
   input  shp_pkg::word_type        data,
   input  shp_pkg::count_type       byte_count,
   output shp_pkg::fin_handoff_type handoff
);

   shp_pkg::sip_state_type v_ff, v_in, v_abs;
   shp_pkg::word_type      partial_ff, partial_in, partial_next;
   shp_pkg::len_type       len_ff, len_in, len_next;
   shp_pkg::count_type     cnt;
   shp_pkg::count_type     fill;
   shp_pkg::word_type      mask, dm, merged, spill;
   logic [2:0]             off;
   logic                   full;

   always_comb begin
      cnt    = (byte_count > shp_pkg::MAX_BYTES) ? shp_pkg::MAX_BYTES : byte_count;
      off    = len_ff[2:0];
      mask   = ~({64{1'b1}} << {cnt, 3'b000});
      dm     = data & mask;
      merged = partial_ff | (dm << {off, 3'b000});
      // bytes that run past the current word; shift of 64 clears all
      spill  = dm >> (7'd64 - {1'b0, off, 3'b000});
      fill   = {1'b0, off} + cnt;
      full   = fill[3];
      len_next     = len_ff + {4'b0000, cnt};
      partial_next = full ? spill : merged;
      v_abs        = full ? shp_pkg::sip_compress(v_ff, merged) : v_ff;
   end

   assign handoff.v     = v_abs;
   assign handoff.block = partial_next | (shp_pkg::word_type'(len_next) << shp_pkg::LEN_POS);

   always_comb begin
      v_in       = v_ff;
      partial_in = partial_ff;
      len_in     = len_ff;
      if (ctrl.restart || (ctrl.accept && ctrl.close)) begin
         v_in       = shp_pkg::sip_init(key_low, key_high);
         partial_in = '0;
         len_in     = '0;
      end else if (ctrl.accept) begin
         v_in       = v_abs;
         partial_in = partial_next;
         len_in     = len_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff       <= shp_pkg::sip_init('0, '0);
         partial_ff <= '0;
         len_ff     <= '0;
      end else begin
         v_ff       <= v_in;
         partial_ff <= partial_in;
         len_ff     <= len_in;
      end
   end

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      ctrl.accept && ctrl.close |=> len_ff == '0 && partial_ff == '0)
      else $error("state not cleared after closing transaction");

   a_len_tracks: assert property (@(posedge clock) disable iff (reset)
      ctrl.accept && !ctrl.close && !ctrl.restart |=> len_ff == $past(len_next))
      else $error("length count lost track of bytes");

endmodule

// ===== sv/shp_finalise.sv =====
// three-stage finalisation pipeline with output register and stall chain
module shp_finalise (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  shp_pkg::fin_handoff_type handoff,
   output logic                     in_stall,
   output logic                     out_valid,
   input  logic                     out_stall,
   output shp_pkg::word_type        out_tag
);

   logic                     s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   shp_pkg::fin_handoff_type s1_ff;
   shp_pkg::sip_state_type   s2_ff, s2_in, s3_ff, s3_in, s4;
   shp_pkg::word_type        tag_ff, tag_in;
   logic                     out_free, s3_free, s2_free, s1_free;

   assign out_free = !out_valid_ff || !out_stall;
   assign s3_free  = !s3_valid_ff || out_free;
   assign s2_free  = !s2_valid_ff || s3_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign in_stall = !s1_free;

   always_comb begin
      s2_in    = shp_pkg::sip_compress(s1_ff.v, s1_ff.block);
      s2_in.v2 = s2_in.v2 ^ shp_pkg::FINAL_XOR;
      s3_in    = shp_pkg::sip_round(shp_pkg::sip_round(s2_ff));
      s4       = shp_pkg::sip_round(shp_pkg::sip_round(s3_ff));
      tag_in   = s4.v0 ^ s4.v1 ^ s4.v2 ^ s4.v3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_free)  s1_valid_ff  <= load;
         if (s2_free)  s2_valid_ff  <= s1_valid_ff;
         if (s3_free)  s3_valid_ff  <= s2_valid_ff;
         if (out_free) out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free && load)          s1_ff  <= handoff;
      if (s2_free && s1_valid_ff)   s2_ff  <= s2_in;
      if (s3_free && s2_valid_ff)   s3_ff  <= s3_in;
      if (out_free && s3_valid_ff)  tag_ff <= tag_in;
   end

   assign out_valid = out_valid_ff;
   assign out_tag   = tag_ff;

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      in_stall |-> s1_valid_ff && s2_valid_ff && s3_valid_ff && out_valid_ff)
      else $error("input stalled with room in the pipeline");

   a_load_lands: assert property (@(posedge clock) disable iff (reset)
      load && !in_stall |=> s1_valid_ff)
      else $error("closing transaction dropped at pipeline entry");

endmodule

// ===== sv/siphash_stream_hasher.sv =====
// top level of the keyed siphash-2-4 stream hasher
//
// usage:
//   csr channel: write key_low (index 0) or key_high (index 1) with
//   csr_valid; csr_ready is always high. a key write restarts the message
//   in progress from the new keys. other indices are ignored. keys are to
//   be written only while the block is idle; the block does not enforce it
//   req channel: one transaction carries up to eight message bytes, byte
//   zero in bits 7:0, a byte count (9..15 treated as 8) and a last flag
//   rsp channel: one transaction with the 64-bit tag per message, issued
//   for each request transaction with last set
// throughput: one request transaction per cycle while req_stall is low; the
//   absorb stage folds a full word with two rounds in the same cycle the bytes are taken
// tag path: the closing block goes through three pipeline stages of two
//   rounds each and then the output register before it is on rsp
// stall: a stalled tag holds in the output register while the three
//   finalisation stages keep filling; req_stall rises only when all of
//   them hold a message
// reset: keys go to zero, the hash state to the bare constants, the
//   pipeline empties
module siphash_stream_hasher (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [63:0]                 req_message_bytes,
   input  logic [3:0]                  req_byte_count,
   input  logic                        req_last,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [63:0]                 rsp_hash_tag,
   // register write channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  shp_pkg::csr_index_type      csr_index,
   input  logic [63:0]                 csr_wdata
);

   shp_pkg::word_type        key_low_ff, key_low_in;
   shp_pkg::word_type        key_high_ff, key_high_in;
   shp_pkg::absorb_ctrl_type ctrl;
   shp_pkg::fin_handoff_type handoff;
   logic                     csr_write, restart, req_accept;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_accept = req_valid && !req_stall;

   // register decode; a write to an unknown index changes nothing
   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      restart     = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            shp_pkg::CSR_KEY_LOW: begin
               key_low_in = csr_wdata;
               restart    = 1'b1;
            end
            shp_pkg::CSR_KEY_HIGH: begin
               key_high_in = csr_wdata;
               restart     = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
      end
   end

   assign ctrl.accept  = req_accept;
   assign ctrl.close   = req_last;
   assign ctrl.restart = restart;

   // running state: packs bytes and compresses each completed word
   shp_absorb u_absorb (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .key_low    (key_low_in),
      .key_high   (key_high_in),
      .data       (req_message_bytes),
      .byte_count (req_byte_count),
      .handoff    (handoff)
   );

   // closing block, finalisation rounds and the tag register
   shp_finalise u_finalise (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept && req_last),
      .handoff   (handoff),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_tag   (rsp_hash_tag)
   );

   a_keys_hold: assert property (@(posedge clock) disable iff (reset)
      !csr_write |=> key_low_ff == $past(key_low_ff) && key_high_ff == $past(key_high_ff))
      else $error("key changed without a register write");

endmodule

// ===== tb/siphash_checker.sv =====
// checker for the siphash stream hasher: tag prediction and comparison
`timescale 1ns / 1ps
module siphash_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [63:0]            req_message_bytes,
   input  logic [3:0]             req_byte_count,
   input  logic                   req_last,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [63:0]            rsp_hash_tag,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  shp_pkg::csr_index_type csr_index,
   input  logic [63:0]            csr_wdata,
   output int                     fail_count,
   output int                     pending_tags
);

   localparam shp_pkg::word_type START_V0 = 64'h736f6d6570736575;
   localparam shp_pkg::word_type START_V1 = 64'h646f72616e646f6d;
   localparam shp_pkg::word_type START_V2 = 64'h6c7967656e657261;
   localparam shp_pkg::word_type START_V3 = 64'h7465646279746573;

   shp_pkg::word_type      key0;
   shp_pkg::word_type      key1;
   shp_pkg::sip_state_type hash_state;
   shp_pkg::word_type      gather_word;
   shp_pkg::len_type       byte_total;
   shp_pkg::word_type      tag_queue[$];
   shp_pkg::word_type      expected_tag;

   function automatic shp_pkg::word_type rol64(input shp_pkg::word_type x,
                                               input int unsigned n);
      return (x << n) | (x >> (64 - n));
   endfunction

   function automatic shp_pkg::sip_state_type sip_mix(input shp_pkg::sip_state_type s);
      shp_pkg::sip_state_type t;
      t    = s;
      t.v0 = t.v0 + t.v1;
      t.v1 = rol64(t.v1, 13) ^ t.v0;
      t.v0 = rol64(t.v0, 32);
      t.v2 = t.v2 + t.v3;
      t.v3 = rol64(t.v3, 16) ^ t.v2;
      t.v0 = t.v0 + t.v3;
      t.v3 = rol64(t.v3, 21) ^ t.v0;
      t.v2 = t.v2 + t.v1;
      t.v1 = rol64(t.v1, 17) ^ t.v2;
      t.v2 = rol64(t.v2, 32);
      return t;
   endfunction

   function automatic shp_pkg::sip_state_type fold_word(input shp_pkg::sip_state_type s,
                                                        input shp_pkg::word_type m);
      shp_pkg::sip_state_type t;
      t    = s;
      t.v3 = t.v3 ^ m;
      t    = sip_mix(sip_mix(t));
      t.v0 = t.v0 ^ m;
      return t;
   endfunction

   task automatic restart_message();
      hash_state.v0 = START_V0 ^ key0;
      hash_state.v1 = START_V1 ^ key1;
      hash_state.v2 = START_V2 ^ key0;
      hash_state.v3 = START_V3 ^ key1;
      gather_word   = '0;
      byte_total    = '0;
   endtask

   // bytes go in at the running offset; counts above eight take eight
   task automatic absorb_request(input shp_pkg::word_type data, input shp_pkg::count_type cnt,
                                 input logic closes);
      int n;
      int i;
      int pos;
      n = (cnt > 4'd8) ? 8 : int'(cnt);
      for (i = 0; i < n; i++) begin
         pos = int'(byte_total[2:0]);
         gather_word[8*pos +: 8] = data[8*i +: 8];
         byte_total = byte_total + 8'd1;
         if (byte_total[2:0] == 3'd0) begin
            hash_state  = fold_word(hash_state, gather_word);
            gather_word = '0;
         end
      end
      if (closes) begin
         hash_state    = fold_word(hash_state, gather_word | {byte_total, 56'd0});
         hash_state.v2 = hash_state.v2 ^ 64'hff;
         repeat (4) hash_state = sip_mix(hash_state);
         tag_queue.push_back(hash_state.v0 ^ hash_state.v1 ^ hash_state.v2 ^ hash_state.v3);
         restart_message();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         key0 = '0;
         key1 = '0;
         restart_message();
         tag_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               shp_pkg::CSR_KEY_LOW: begin
                  key0 = csr_wdata;
                  restart_message();
               end
               shp_pkg::CSR_KEY_HIGH: begin
                  key1 = csr_wdata;
                  restart_message();
               end
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            absorb_request(req_message_bytes, req_byte_count, req_last);
         if (rsp_valid && !rsp_stall) begin
            if (tag_queue.size() == 0) begin
               $display("%0t: unexpected tag, expected none, got %h", $time, rsp_hash_tag);
               fail_count++;
            end else begin
               expected_tag = tag_queue.pop_front();
               if (rsp_hash_tag !== expected_tag) begin
                  $display("%0t: hash_tag mismatch, expected %h, got %h",
                           $time, expected_tag, rsp_hash_tag);
                  fail_count++;
               end
            end
         end
      end
      pending_tags = tag_queue.size();
   end

endmodule

// ===== tb/tb_siphash_stream_hasher.sv =====
// testbench top for the siphash stream hasher: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module tb_siphash_stream_hasher;

   localparam int RESET_CYCLES = 11;
   localparam int HOLD_CYCLES  = 80;       // long receiver hold-off for back-pressure
   localparam int DRAIN_CYCLES = 10;       // margin after the last tag for the pipeline to drain
   localparam int LIMIT_CYCLES = 100000;
   localparam int RANDOM_ITEMS = 350;

   // indices the block does not decode
   localparam shp_pkg::csr_index_type CSR_SPARE_A = 2'd2;
   localparam shp_pkg::csr_index_type CSR_SPARE_B = 2'd3;

   localparam shp_pkg::word_type ALL_ONES = '1;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_SPARSE,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   logic                   clock             = 1'b0;
   logic                   reset             = 1'b1;
   logic                   req_valid         = 1'b0;
   logic                   req_stall;
   logic [63:0]            req_message_bytes = '0;
   logic [3:0]             req_byte_count    = '0;
   logic                   req_last          = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall         = 1'b0;
   logic [63:0]            rsp_hash_tag;
   logic                   csr_valid         = 1'b0;
   logic                   csr_ready;
   shp_pkg::csr_index_type csr_index         = shp_pkg::CSR_KEY_LOW;
   logic [63:0]            csr_wdata         = '0;

   int fail_count;
   int pending_tags;
   int cycle_count = 0;
   int items_sent  = 0;

   // sender burst control
   int burst_left = 0;
   bit no_gaps    = 1'b0;

   // receiver stall control
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left  = 0;
   int             hold_left  = 0;
   bit             hold_pending = 1'b0;

   siphash_stream_hasher uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_message_bytes (req_message_bytes),
      .req_byte_count    (req_byte_count),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hash_tag      (rsp_hash_tag),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   siphash_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_message_bytes (req_message_bytes),
      .req_byte_count    (req_byte_count),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hash_tag      (rsp_hash_tag),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .pending_tags      (pending_tags)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog: a hung handshake ends the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: switches between stall patterns now and then, and serves a long
   // hold-off when the stimulus asks for one; exactly one update per falling edge
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(10, 60);
      end
      mode_left--;
      if (hold_pending) begin
         hold_pending = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_SPARSE:   rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: rsp_stall <= (mode_left % 3 == 0);
            default:        rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // one request transaction; gaps come between bursts of random length, and
   // valid stays high from one item to the next inside a burst
   task automatic send_item(input shp_pkg::word_type data, input shp_pkg::count_type cnt,
                            input logic closes);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         if (no_gaps) begin
            burst_left = 1;
         end else begin
            gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_message_bytes <= data;
      req_byte_count    <= cnt;
      req_last          <= closes;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // drop valid and wait until every tag is back and the pipeline has drained
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_tags == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input shp_pkg::csr_index_type idx, input shp_pkg::word_type data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_keys(input shp_pkg::word_type k0, input shp_pkg::word_type k1);
      write_csr(shp_pkg::CSR_KEY_LOW, k0);
      write_csr(shp_pkg::CSR_KEY_HIGH, k1);
   endtask

   // a message of nbytes in random chunks with junk above each count; some
   // items carry no bytes, full chunks sometimes use an oversized count, and
   // the close may come on a separate empty item
   task automatic send_message(input int nbytes, input bit split_close);
      int                 remaining;
      int                 take;
      shp_pkg::count_type cnt;
      remaining = nbytes;
      while (remaining > 0) begin
         take = $urandom_range(1, (remaining < 8) ? remaining : 8);
         if ($urandom_range(0, 9) == 0)
            take = 0;
         cnt = shp_pkg::count_type'(take);
         if (take == 8 && $urandom_range(0, 2) == 0)
            cnt = shp_pkg::count_type'($urandom_range(9, 15));
         remaining -= take;
         send_item({$urandom, $urandom}, cnt, (remaining == 0) && !split_close);
      end
      if (nbytes == 0 || split_close)
         send_item({$urandom, $urandom}, shp_pkg::count_type'($urandom_range(0, 1) ? 0 : 0),
                   1'b1);
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6)
         return $urandom_range(0, 16);
      else if (r < 9)
         return $urandom_range(17, 64);
      else
         return $urandom_range(65, 120);
   endfunction

   int  random_start;
   int  phase_items;
   int  phase_index;
   bit  long_done;

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, with the reset keys of zero
      send_item(64'h0123456789abcdef, 4'd0, 1'b1);   // empty message
      send_item(ALL_ONES, 4'd0, 1'b0);               // nothing to absorb
      send_item(ALL_ONES, 4'd8, 1'b1);               // one full word of 0xff
      send_item(ALL_ONES, 4'd15, 1'b1);              // oversized count saturates
      send_item('0, 4'd9, 1'b0);
      send_item(64'hffffffffffffffff, 4'd1, 1'b1);   // nine bytes across a word
      send_item(ALL_ONES, 4'd7, 1'b1);               // junk in the byte above the count
      send_item('0, 4'd1, 1'b1);
      send_item({$urandom, $urandom}, 4'd12, 1'b0);
      send_item({$urandom, $urandom}, 4'd8, 1'b0);
      send_item(ALL_ONES, 4'd0, 1'b1);               // close on a word boundary
      settle();

      // published test keys, fifteen bytes 00..0e
      load_keys(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
      send_item(64'h0706050403020100, 4'd8, 1'b0);
      send_item(64'hff0e0d0c0b0a0908, 4'd7, 1'b1);
      settle();

      // extreme keys, plus writes to undecoded indices that must change nothing
      load_keys(ALL_ONES, ALL_ONES);
      write_csr(CSR_SPARE_A, ALL_ONES);
      write_csr(CSR_SPARE_B, {$urandom, $urandom});
      send_item(ALL_ONES, 4'd3, 1'b1);
      send_item('0, 4'd0, 1'b1);

      // leave a message open, then a key write abandons it
      send_item(ALL_ONES, 4'd5, 1'b0);
      settle();
      write_csr(shp_pkg::CSR_KEY_LOW, '0);
      send_item(64'h8000000000000001, 4'd8, 1'b1);
      settle();

      // back-pressure: the receiver holds off while single-item messages keep
      // coming, so the finalisation stages fill and the input stalls
      write_csr(shp_pkg::CSR_KEY_HIGH, '0);
      no_gaps      = 1'b1;
      burst_left   = 0;
      hold_pending = 1'b1;
      repeat (10)
         send_item({$urandom, $urandom}, shp_pkg::count_type'($urandom_range(0, 8)), 1'b1);
      no_gaps = 1'b0;
      settle();

      // random phases, each with fresh keys; extremes come up now and then
      random_start = items_sent;
      phase_index  = 0;
      long_done    = 1'b0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0:       load_keys('0, ALL_ONES);
            1:       load_keys(ALL_ONES, '0);
            // only one half changes
            2:       write_csr(shp_pkg::CSR_KEY_LOW, {$urandom, $urandom});
            default: load_keys({$urandom, $urandom}, {$urandom, $urandom});
         endcase
         phase_items = items_sent;
         // one message long enough for the length byte to wrap
         if (!long_done && phase_index == 2) begin
            send_message(300, 1'b0);
            long_done = 1'b1;
         end
         while (items_sent - phase_items < 40)
            send_message(pick_length(), ($urandom_range(0, 4) == 0));
         // sometimes leave a message half done for the next key write to drop
         if ($urandom_range(0, 2) == 0)
            send_item({$urandom, $urandom}, shp_pkg::count_type'($urandom_range(0, 15)), 1'b0);
         settle();
         phase_index++;
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== siphash_stream_hasher.f =====
sv/shp_pkg.sv
sv/shp_absorb.sv
sv/shp_finalise.sv
sv/siphash_stream_hasher.sv
tb/siphash_checker.sv
tb/tb_siphash_stream_hasher.sv
